// ===== rtl/piecewise_linear_curve_lookup_core_defines.svh =====
// Assertion helpers shared by the curve lookup RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication
`define PLC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication
`define PLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/plc_pkg.sv =====
package plc_pkg;

    // Table capacity default and internal queue depth
    localparam int MAX_POINTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    // Quotient bits produced by the serial divider
    localparam int DIV_STEPS = 16;

    // Action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Region codes
    localparam logic [1:0] REGION_EMPTY  = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;
    localparam logic [1:0] REGION_INTERP = 2'd3;

    // Input word
    typedef struct packed {
        logic               action;
        logic [3:0]         point_index;
        logic [15:0]        point_speed;
        logic signed [15:0] point_value;
        logic [15:0]        query_speed;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [15:0] sampled_value;
        logic [1:0]         region;
    } out_word_t;

    // Classified word held in the queue
    typedef struct packed {
        logic        is_sample;
        logic [3:0]  slot;
        logic [15:0] speed;
        logic [15:0] value;
        logic [15:0] query;
    } qent_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        qent_t entry;
    } head_t;

endpackage

// ===== rtl/plc_ram.sv =====
module plc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/plc_front.sv =====
module plc_front #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  plc_pkg::in_word_t in_word,
    output plc_pkg::head_t    head,
    input  logic              pop
);
    import plc_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    qent_t           q_mem [QUEUE_DEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            full;
    logic            accept;
    logic            slot_ok;
    logic            push;
    qent_t           ent;

    // Accept while the queue has room
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Classify: writes to slots past capacity are dropped here
    assign slot_ok = (int'(in_word.point_index) < MAX_POINTS);
    assign push    = accept && ((in_word.action == ACT_SAMPLE) || slot_ok);

    always_comb
    begin
        ent.is_sample = (in_word.action == ACT_SAMPLE);
        ent.slot      = in_word.point_index;
        ent.speed     = in_word.point_speed;
        ent.value     = in_word.point_value;
        ent.query     = in_word.query_speed;
    end

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= ent;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = q_mem[rd_ptr_reg];

endmodule

// ===== rtl/plc_back.sv =====
module plc_back #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  plc_pkg::head_t     head,
    output logic               pop,
    input  logic [4:0]         point_count,
    output logic               out_valid,
    input  logic               out_stall,
    output plc_pkg::out_word_t out_word
);
    import plc_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LAST  = 7'b0000010,
        ST_FIRST = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_SUM   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [15:0]   rd_speed;
    logic [15:0]   rd_value;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] last_idx;

    logic [15:0]   query_reg, query_next;
    logic [15:0]   last_spd_reg, last_spd_next;
    logic [15:0]   last_val_reg, last_val_next;
    logic [15:0]   prev_spd_reg, prev_spd_next;
    logic [15:0]   prev_val_reg, prev_val_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [15:0]   dq_reg, dq_next;
    logic [15:0]   den_reg, den_next;
    logic          dv_neg_reg, dv_neg_next;
    logic [15:0]   dv_mag_reg, dv_mag_next;
    logic [31:0]   acc_reg, acc_next;
    logic [3:0]    step_reg, step_next;
    logic [15:0]   res_val_reg, res_val_next;
    logic [1:0]    res_region_reg, res_region_next;
    logic          done_reg, done_next;

    logic          out_valid_reg, out_valid_next;
    out_word_t     out_word_reg, out_word_next;

    logic signed [16:0] dv;
    logic [16:0]        dv_abs;
    logic [16:0]        trial;
    logic signed [17:0] quo_s;
    logic signed [17:0] sum;
    logic               out_free;

    // Table storage: speed in the upper half, value in the lower
    plc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_speed = ram_rdata[31:16];
    assign rd_value = ram_rdata[15:0];

    // Points in use, clamped to capacity
    always_comb
    begin
        if (int'(point_count) > MAX_POINTS)
        begin
            n_eff = NW'(MAX_POINTS);
        end
        else
        begin
            n_eff = NW'(point_count);
        end
    end
    assign last_idx = n_eff - NW'(1);

    // Span difference for the enclosing pair
    assign dv     = $signed({rd_value[15], rd_value})
                  - $signed({prev_val_reg[15], prev_val_reg});
    assign dv_abs = dv[16] ? 17'(-dv) : 17'(dv);

    // One restoring divide step
    assign trial = acc_reg[31:15];

    // Sign the quotient and add the base value
    assign quo_s = dv_neg_reg ? -$signed({2'b00, acc_reg[15:0]})
                              : $signed({2'b00, acc_reg[15:0]});
    assign sum   = $signed({{2{prev_val_reg[15]}}, prev_val_reg}) + quo_s;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && !done_reg && head.valid;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        query_next      = query_reg;
        last_spd_next   = last_spd_reg;
        last_val_next   = last_val_reg;
        prev_spd_next   = prev_spd_reg;
        prev_val_next   = prev_val_reg;
        idx_next        = idx_reg;
        dq_next         = dq_reg;
        den_next        = den_reg;
        dv_neg_next     = dv_neg_reg;
        dv_mag_next     = dv_mag_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        res_val_next    = res_val_reg;
        res_region_next = res_region_reg;
        done_next       = done_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(head.entry.slot);
        ram_wdata       = {head.entry.speed, head.entry.value};
        ram_raddr       = AW'(last_idx);
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;

        // Hand a finished result to the output register
        if (done_reg && out_free)
        begin
            out_valid_next              = 1'b1;
            out_word_next.sampled_value = res_val_reg;
            out_word_next.region        = res_region_reg;
            done_next                   = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (!head.entry.is_sample)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (n_eff == '0)
                    begin
                        res_val_next    = '0;
                        res_region_next = REGION_EMPTY;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        query_next = head.entry.query;
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST:
            begin
                last_spd_next = rd_speed;
                last_val_next = rd_value;
                ram_raddr     = '0;
                state_next    = ST_FIRST;
            end
            ST_FIRST:
            begin
                ram_raddr = AW'(1);
                if (query_reg <= rd_speed)
                begin
                    res_val_next    = rd_value;
                    res_region_next = REGION_BELOW;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (query_reg >= last_spd_reg)
                begin
                    res_val_next    = last_val_reg;
                    res_region_next = REGION_ABOVE;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    prev_spd_next = rd_speed;
                    prev_val_next = rd_value;
                    idx_next      = NW'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_raddr = AW'(idx_reg + NW'(1));
                if (query_reg <= rd_speed)
                begin
                    if (rd_speed <= prev_spd_reg)
                    begin
                        // Empty or reversed span: previous value
                        res_val_next    = prev_val_reg;
                        res_region_next = REGION_INTERP;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        dq_next     = query_reg - prev_spd_reg;
                        den_next    = rd_speed - prev_spd_reg;
                        dv_neg_next = dv[16];
                        dv_mag_next = dv_abs[15:0];
                        state_next  = ST_MUL;
                    end
                end
                else if (idx_reg == last_idx)
                begin
                    // Unordered table, nothing at or above the query
                    res_val_next    = last_val_reg;
                    res_region_next = REGION_ABOVE;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    prev_spd_next = rd_speed;
                    prev_val_next = rd_value;
                    idx_next      = idx_reg + NW'(1);
                end
            end
            ST_MUL:
            begin
                acc_next   = {16'b0, dq_reg} * {16'b0, dv_mag_reg};
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Partial remainder stays below the divisor, quotient fits 16 bits
                if (trial >= {1'b0, den_reg})
                begin
                    acc_next = {16'(trial - {1'b0, den_reg}), acc_reg[14:0], 1'b1};
                end
                else
                begin
                    acc_next = {trial[15:0], acc_reg[14:0], 1'b0};
                end
                step_next = step_reg + 4'(1);
                if (step_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (!done_reg)
                begin
                    if (sum > 18'sd32767)
                    begin
                        res_val_next = 16'h7FFF;
                    end
                    else if (sum < -18'sd32768)
                    begin
                        res_val_next = 16'h8000;
                    end
                    else
                    begin
                        res_val_next = sum[15:0];
                    end
                    res_region_next = REGION_INTERP;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        query_reg      <= query_next;
        last_spd_reg   <= last_spd_next;
        last_val_reg   <= last_val_next;
        prev_spd_reg   <= prev_spd_next;
        prev_val_reg   <= prev_val_next;
        idx_reg        <= idx_next;
        dq_reg         <= dq_next;
        den_reg        <= den_next;
        dv_neg_reg     <= dv_neg_next;
        dv_mag_reg     <= dv_mag_next;
        acc_reg        <= acc_next;
        step_reg       <= step_next;
        res_val_reg    <= res_val_next;
        res_region_reg <= res_region_next;
        out_word_reg   <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== rtl/piecewise_linear_curve_lookup_core.sv =====
// Piecewise linear curve lookup. Write words load one breakpoint (speed,
// value) into a table of MAX_POINTS slots; sample words return the clamped
// or interpolated value at a query speed, plus a region code. A front end
// accepts and classifies words into a two-word queue; a back end owns the
// table RAM and runs one word at a time. A sample on an empty table
// returns zero. The back end reads one RAM word per scanned breakpoint;
// when the span ending at breakpoint n is empty or reversed it returns
// the value at breakpoint n-1; to interpolate between breakpoints n-1
// and n it uses a multiply and a 16-step restoring divider. A stalled
// output holds the back end until the output register frees up; once
// the result sits there, the back end goes on with the next word while
// it waits. The user must write point_count only while the block is idle,
// as the block itself does not enforce it; table slots must be written
// before they are sampled.
`include "piecewise_linear_curve_lookup_core_defines.svh"

module piecewise_linear_curve_lookup_core #(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [4:0]         cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  plc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output plc_pkg::out_word_t out_word
);
    import plc_pkg::*;

    logic [4:0] point_count_reg;
    head_t      head;
    logic       pop;

    // Breakpoint count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            point_count_reg <= cfg_write_data;
        end
    end

    // Accept and classify
    plc_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .head     (head),
        .pop      (pop)
    );

    // Table, search and interpolation
    plc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .point_count (point_count_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word)
    );

    // A full queue always offers a word to the back end
    `PLC_ASSERT_IMPL(a_full_has_head, in_stall, head.valid)
    // The back end never takes from an empty queue
    `PLC_ASSERT_IMPL(a_pop_has_head, pop, head.valid)
    // A table write never produces a result
    `PLC_ASSERT_NEXT(a_write_no_result, pop && !head.entry.is_sample, !$rose(out_valid))

endmodule
